// ===== hw/rtl/pft_pkg.sv =====
// Shared types and constants for the trial-division prime factorizer.
package pft_pkg;

    // Width of the factor field on the result channel.
    localparam int FACTOR_W = 32;

    // Most results one input can produce.
    localparam int MAX_RESULTS = 32;

    // Width of the result counter.
    localparam int K_W = $clog2(MAX_RESULTS);

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NONE,
        ST_SQ,
        ST_CMP,
        ST_REDIV,
        ST_DIV,
        ST_CHECK,
        ST_EMIT_D,
        ST_EMIT_LIMIT,
        ST_EMIT_ONE,
        ST_EMIT_REST
    } state_t;

    // Source of the factor field when a result is loaded.
    typedef enum logic [1:0] {
        OSEL_NONE,
        OSEL_DIV,
        OSEL_ONE,
        OSEL_REST
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     sq_load;
        logic     div_start;
        logic     div_step;
        logic     take_quot;
        logic     inc_d;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_small;
        logic sq_le;
        logic div_done;
        logic rem_zero;
        logic quo_one;
        logic k_full;
        logic found;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/pft_ctrl.sv =====
// Controller state machine that sequences the trial-division datapath.
module pft_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pft_pkg::status_t  status,
    output pft_pkg::cmd_t     cmd
);

    pft_pkg::state_t state_reg;
    pft_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pft_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.in_small ? pft_pkg::ST_NONE : pft_pkg::ST_SQ;
                end
            end
            pft_pkg::ST_NONE: begin
                if (status.out_free) begin
                    state_next = pft_pkg::ST_IDLE;
                end
            end
            pft_pkg::ST_SQ: begin
                state_next = pft_pkg::ST_CMP;
            end
            pft_pkg::ST_CMP: begin
                // Past the square root: what is left decides the final results.
                if (status.sq_le) begin
                    state_next = pft_pkg::ST_DIV;
                end else if (status.found) begin
                    state_next = pft_pkg::ST_EMIT_REST;
                end else begin
                    state_next = pft_pkg::ST_EMIT_ONE;
                end
            end
            pft_pkg::ST_REDIV: begin
                state_next = pft_pkg::ST_DIV;
            end
            pft_pkg::ST_DIV: begin
                if (status.div_done) begin
                    state_next = pft_pkg::ST_CHECK;
                end
            end
            pft_pkg::ST_CHECK: begin
                if (!status.rem_zero) begin
                    state_next = pft_pkg::ST_SQ;
                end else if (status.k_full) begin
                    state_next = pft_pkg::ST_EMIT_LIMIT;
                end else begin
                    state_next = pft_pkg::ST_EMIT_D;
                end
            end
            pft_pkg::ST_EMIT_D: begin
                // A quotient of one means the number is fully factored.
                if (status.out_free) begin
                    state_next = status.quo_one ? pft_pkg::ST_IDLE : pft_pkg::ST_REDIV;
                end
            end
            pft_pkg::ST_EMIT_LIMIT: begin
                if (status.out_free) begin
                    state_next = pft_pkg::ST_IDLE;
                end
            end
            pft_pkg::ST_EMIT_ONE: begin
                if (status.out_free) begin
                    state_next = pft_pkg::ST_EMIT_REST;
                end
            end
            pft_pkg::ST_EMIT_REST: begin
                if (status.out_free) begin
                    state_next = pft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pft_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.sq_load   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.take_quot = 1'b0;
        cmd.inc_d     = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_sel   = pft_pkg::OSEL_NONE;
        cmd.out_last  = 1'b0;
        unique case (state_reg)
            pft_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            pft_pkg::ST_NONE: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = pft_pkg::OSEL_NONE;
                cmd.out_last = 1'b1;
            end
            pft_pkg::ST_SQ: begin
                cmd.sq_load = 1'b1;
            end
            pft_pkg::ST_CMP: begin
                cmd.div_start = status.sq_le;
            end
            pft_pkg::ST_REDIV: begin
                cmd.div_start = 1'b1;
            end
            pft_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            pft_pkg::ST_CHECK: begin
                cmd.inc_d = !status.rem_zero;
            end
            pft_pkg::ST_EMIT_D: begin
                cmd.out_load  = status.out_free;
                cmd.take_quot = status.out_free;
                cmd.out_sel   = pft_pkg::OSEL_DIV;
                cmd.out_last  = status.quo_one;
            end
            pft_pkg::ST_EMIT_LIMIT: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = pft_pkg::OSEL_REST;
                cmd.out_last = 1'b1;
            end
            pft_pkg::ST_EMIT_ONE: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = pft_pkg::OSEL_ONE;
                cmd.out_last = 1'b0;
            end
            pft_pkg::ST_EMIT_REST: begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = pft_pkg::OSEL_REST;
                cmd.out_last = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pft_dp.sv =====
// Datapath: cofactor, trial divisor, squarer, bit-serial divider and output register.
module pft_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pft_pkg::cmd_t                     cmd,
    output pft_pkg::status_t                  status,
    input  logic [VALUE_WIDTH-1:0]            s_value,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [pft_pkg::FACTOR_W-1:0]      m_factor,
    output logic                              m_last,
    output logic                              m_no_factors
);

    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW = 2 * DW;
    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int FW = pft_pkg::FACTOR_W;
    localparam int KW = pft_pkg::K_W;

    logic [VALUE_WIDTH-1:0] c_reg;
    logic [DW-1:0]          d_reg;
    logic [SW-1:0]          sq_reg;
    logic [DW-1:0]          rem_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [CW-1:0]          cnt_reg;
    logic [KW-1:0]          k_reg;
    logic                   found_reg;
    logic                   m_valid_reg;
    logic [FW-1:0]          factor_reg;
    logic                   last_reg;
    logic                   nf_reg;

    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   no_borrow;

    // Cofactor, trial divisor and result count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg     <= '0;
            d_reg     <= DW'(2);
            k_reg     <= '0;
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            c_reg     <= s_value;
            d_reg     <= DW'(2);
            k_reg     <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.inc_d) begin
                d_reg <= d_reg + 1'b1;
            end
            if (cmd.take_quot) begin
                c_reg     <= quo_reg;
                k_reg     <= k_reg + 1'b1;
                found_reg <= 1'b1;
            end
        end
    end

    // Square of the trial divisor, compared against the cofactor next cycle.
    always_ff @(posedge aclk) begin
        if (cmd.sq_load) begin
            sq_reg <= SW'(d_reg) * SW'(d_reg);
        end
    end

    // One restoring-division step: shift in a cofactor bit, subtract if it fits.
    assign trial     = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff      = trial - {1'b0, d_reg};
    assign no_borrow = !diff[DW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= c_reg;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= no_borrow ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], no_borrow};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Output register; it frees as soon as the current beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            last_reg <= cmd.out_last;
            unique case (cmd.out_sel)
                pft_pkg::OSEL_NONE: begin
                    factor_reg <= '0;
                    nf_reg     <= 1'b1;
                end
                pft_pkg::OSEL_DIV: begin
                    factor_reg <= FW'(d_reg);
                    nf_reg     <= 1'b0;
                end
                pft_pkg::OSEL_ONE: begin
                    factor_reg <= FW'(1);
                    nf_reg     <= 1'b0;
                end
                pft_pkg::OSEL_REST: begin
                    factor_reg <= FW'(c_reg);
                    nf_reg     <= 1'b0;
                end
                default: begin
                    factor_reg <= '0;
                    nf_reg     <= 1'b0;
                end
            endcase
        end
    end

    // Status back to the controller.
    assign status.in_small = s_value < VALUE_WIDTH'(2);
    assign status.sq_le    = sq_reg <= SW'(c_reg);
    assign status.div_done = cnt_reg == CW'(VALUE_WIDTH - 1);
    assign status.rem_zero = rem_reg == '0;
    assign status.quo_one  = quo_reg == VALUE_WIDTH'(1);
    assign status.k_full   = k_reg == KW'(pft_pkg::MAX_RESULTS - 1);
    assign status.found    = found_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_factor     = factor_reg;
    assign m_last       = last_reg;
    assign m_no_factors = nf_reg;

endmodule

// ===== hw/rtl/prime_factorization_trial_division.sv =====
// Top level of the trial-division prime factorizer.
// Each trial divisor passes through square, compare, bit-serial remainder and check;
// each further division by a divisor that divides passes through emit, restart, remainder
// and check, plus any wait on the output handshake.
// A 32-bit prime takes about 65535 divisors; inputs 0 and 1 give the no-factors beat.
// One number is factored at a time; the next is taken once the final result is loaded.
// Reset (aresetn low, synchronous) empties the output register and returns to idle.
module prime_factorization_trial_division #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_WIDTH-1:0]        s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pft_pkg::FACTOR_W-1:0]  m_factor,
    output logic                          m_last,
    output logic                          m_no_factors
);

    pft_pkg::cmd_t    cmd;
    pft_pkg::status_t status;

    pft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pft_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_value      (s_value),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_factor     (m_factor),
        .m_last       (m_last),
        .m_no_factors (m_no_factors)
    );

endmodule

// ===== hw/rtl/pft_checker.sv =====
// Port-level checker for the prime factorizer, bound to the top level.
module pft_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pft_pkg::FACTOR_W-1:0]  m_factor,
    input logic                          m_last,
    input logic                          m_no_factors
);

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_factor) && $stable(m_last)
            && $stable(m_no_factors))
        else $error("stalled result beat changed");

    // An input with no factors gives a single final beat with a zero factor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_factors |-> m_last && (m_factor == '0))
        else $error("no-factors beat is not a lone zero");

    // While a non-final result is pending, the number is still being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input accepted before the final result");

    // Reset empties the result channel.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new number is only taken when the input side asks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid |=> s_ready)
        else $error("controller left idle without an input beat");

endmodule

bind prime_factorization_trial_division pft_checker u_pft_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_factor     (m_factor),
    .m_last       (m_last),
    .m_no_factors (m_no_factors)
);
